### src/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes of the sorted keyed table.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int KEY_BITS_DEF    = 16;
	localparam int HANDLE_BITS_DEF = 16;

	localparam int OP_BITS     = 2;
	localparam int STATUS_BITS = 2;

	typedef logic [OP_BITS-1:0]     op_t;
	typedef logic [STATUS_BITS-1:0] status_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_FIND   = 2'd1;
	localparam op_t OP_CLEAR  = 2'd2;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_FULL      = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;  // capture request beat
		logic exec;  // run captured op, register result
	} ctl_t;

endpackage

### src/skt_req_if.sv
// ----------------------------------------------------------------------------
// skt_req_if
// Request channel: op, key and handle with valid/ready.
// ----------------------------------------------------------------------------
interface skt_req_if #(
	parameter int KEY_BITS    = skt_pkg::KEY_BITS_DEF,
	parameter int HANDLE_BITS = skt_pkg::HANDLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	skt_pkg::op_t           op;
	logic [KEY_BITS-1:0]    key;
	logic [HANDLE_BITS-1:0] handle;

	modport source (output valid, op, key, handle, input ready);
	modport sink   (input valid, op, key, handle, output ready);
endinterface

### src/skt_rsp_if.sv
// ----------------------------------------------------------------------------
// skt_rsp_if
// Response channel: status, found handle, count and largest key.
// ----------------------------------------------------------------------------
interface skt_rsp_if #(
	parameter int KEY_BITS    = skt_pkg::KEY_BITS_DEF,
	parameter int HANDLE_BITS = skt_pkg::HANDLE_BITS_DEF,
	parameter int CNT_BITS    = $clog2(skt_pkg::DEPTH_DEF + 1)
);
	logic                   valid;
	logic                   ready;
	skt_pkg::status_t       status;
	logic [HANDLE_BITS-1:0] found_handle;
	logic [CNT_BITS-1:0]    count;
	logic [KEY_BITS-1:0]    max_key;

	modport source (output valid, status, found_handle, count, max_key, input ready);
	modport sink   (input valid, status, found_handle, count, max_key, output ready);
endinterface

### src/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer: capture a request beat, execute it, hold the response beat.
// ----------------------------------------------------------------------------
module skt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output skt_pkg::ctl_t ctl
);

	skt_pkg::state_t state_q;
	skt_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skt_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			skt_pkg::S_IDLE: begin
				if (in_valid) state_nxt = skt_pkg::S_EXEC;
			end
			skt_pkg::S_EXEC: begin
				state_nxt = skt_pkg::S_RESP;
			end
			skt_pkg::S_RESP: begin
				if (out_ready) state_nxt = in_valid ? skt_pkg::S_EXEC : skt_pkg::S_IDLE;
			end
			default: begin
				state_nxt = skt_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		ctl.exec  = 1'b0;
		case (state_q)
			skt_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			skt_pkg::S_EXEC: begin
				ctl.exec = 1'b1;
			end
			skt_pkg::S_RESP: begin
				out_valid = 1'b1;
				in_ready  = out_ready;  // next beat taken as the response leaves
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		ctl.load = in_valid && in_ready;
	end

endmodule

### src/skt_dpath.sv
// ----------------------------------------------------------------------------
// skt_dpath
// Register table kept in key order, parallel compare, insert shift and
// result registers.
// ----------------------------------------------------------------------------
module skt_dpath #(
	parameter int DEPTH       = skt_pkg::DEPTH_DEF,
	parameter int KEY_BITS    = skt_pkg::KEY_BITS_DEF,
	parameter int HANDLE_BITS = skt_pkg::HANDLE_BITS_DEF,
	parameter int CNT_BITS    = $clog2(DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  skt_pkg::ctl_t          ctl,
	input  skt_pkg::op_t           in_op,
	input  logic [KEY_BITS-1:0]    in_key,
	input  logic [HANDLE_BITS-1:0] in_handle,
	output skt_pkg::status_t       res_status,
	output logic [HANDLE_BITS-1:0] res_handle,
	output logic [CNT_BITS-1:0]    res_count,
	output logic [KEY_BITS-1:0]    res_max
);

	skt_pkg::op_t           op_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [HANDLE_BITS-1:0] hnd_q;

	logic [KEY_BITS-1:0]    keys_q [DEPTH];
	logic [HANDLE_BITS-1:0] hnds_q [DEPTH];
	logic [CNT_BITS-1:0]    count_q;
	logic [KEY_BITS-1:0]    max_q;

	skt_pkg::status_t       status_q;
	logic [HANDLE_BITS-1:0] fhnd_q;

	logic [DEPTH-1:0]       vld;
	logic [DEPTH-1:0]       le;
	logic [DEPTH-1:0]       eq;
	logic [KEY_BITS-1:0]    nkeys [DEPTH];
	logic [HANDLE_BITS-1:0] nhnds [DEPTH];
	logic                   full;
	logic                   hit;
	logic [HANDLE_BITS-1:0] hit_hnd;
	logic                   do_ins;
	logic                   do_clr;

	assign full   = (count_q == CNT_BITS'(DEPTH));
	assign do_ins = ctl.exec && (op_q == skt_pkg::OP_INSERT) && !full;
	assign do_clr = ctl.exec && (op_q == skt_pkg::OP_CLEAR);

	// le is a thermometer over the valid entries, as the table is sorted
	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_ent
			assign vld[g] = CNT_BITS'(g) < count_q;
			assign le[g]  = vld[g] && (keys_q[g] <= key_q);
			assign eq[g]  = vld[g] && (keys_q[g] == key_q);
			if (g == 0) begin : g_head
				always_comb begin
					nkeys[g] = le[g] ? keys_q[g] : key_q;
					nhnds[g] = le[g] ? hnds_q[g] : hnd_q;
				end
			end else begin : g_body
				always_comb begin
					if (le[g]) begin
						nkeys[g] = keys_q[g];
						nhnds[g] = hnds_q[g];
					end else if (le[g-1]) begin
						nkeys[g] = key_q;
						nhnds[g] = hnd_q;
					end else begin
						nkeys[g] = keys_q[g-1];
						nhnds[g] = hnds_q[g-1];
					end
				end
			end
		end
	endgenerate

	// first match wins
	always_comb begin
		hit     = 1'b0;
		hit_hnd = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (eq[i] && !hit) begin
				hit     = 1'b1;
				hit_hnd = hnds_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q  <= in_op;
			key_q <= in_key;
			hnd_q <= in_handle;
		end
		if (do_ins) begin
			for (int i = 0; i < DEPTH; i++) begin
				keys_q[i] <= nkeys[i];
				hnds_q[i] <= nhnds[i];
			end
		end
		if (ctl.exec) begin
			case (op_q)
				skt_pkg::OP_INSERT: begin
					status_q <= full ? skt_pkg::ST_FULL : skt_pkg::ST_OK;
					fhnd_q   <= '0;
				end
				skt_pkg::OP_FIND: begin
					status_q <= hit ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
					fhnd_q   <= hit_hnd;
				end
				default: begin
					status_q <= skt_pkg::ST_OK;
					fhnd_q   <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q   <= '0;
		end else if (do_clr) begin
			count_q <= '0;
			max_q   <= '0;
		end else if (do_ins) begin
			count_q <= count_q + CNT_BITS'(1);
			if (count_q == '0 || key_q >= max_q) max_q <= key_q;
		end
	end

	assign res_status = status_q;
	assign res_handle = fhnd_q;
	assign res_count  = count_q;
	assign res_max    = max_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(DEPTH))
		else $error("entry count beyond table depth");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		do_clr |=> (count_q == '0) && (max_q == '0))
		else $error("clear left entries behind");

	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> count_q == $past(count_q) + CNT_BITS'(1))
		else $error("insert did not add one entry");

	a_empty_max: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (max_q == '0))
		else $error("largest key non-zero on empty table");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_BITS'(2)) |-> (keys_q[0] <= keys_q[1]))
		else $error("head entries out of key order");

endmodule

### src/sorted_keyed_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_keyed_table_unit
// Table of up to DEPTH key/handle entries held in ascending key order; an
// insert goes after every entry with a key less than or equal to its own
// and is refused with status full when the table is full, a find returns
// the handle of the first entry with the key, a clear empties the table,
// and every response beat carries the entry count and the largest key held
// (0 when empty). A request beat is captured, then the whole table is
// compared against the key in parallel and shifted by one place, and the
// result sits in an output register. The next request beat is taken in
// the same cycle that the response beat leaves, so a new request is never
// taken before the response to the last one has left.
// ----------------------------------------------------------------------------
module sorted_keyed_table_unit #(
	parameter int DEPTH       = skt_pkg::DEPTH_DEF,
	parameter int KEY_BITS    = skt_pkg::KEY_BITS_DEF,
	parameter int HANDLE_BITS = skt_pkg::HANDLE_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	skt_req_if.sink  req,
	skt_rsp_if.source rsp
);

	localparam int CNT_BITS = $clog2(DEPTH + 1);

	skt_pkg::ctl_t ctl;

	skt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.ctl       (ctl)
	);

	skt_dpath #(
		.DEPTH       (DEPTH),
		.KEY_BITS    (KEY_BITS),
		.HANDLE_BITS (HANDLE_BITS),
		.CNT_BITS    (CNT_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.in_op      (req.op),
		.in_key     (req.key),
		.in_handle  (req.handle),
		.res_status (rsp.status),
		.res_handle (rsp.found_handle),
		.res_count  (rsp.count),
		.res_max    (rsp.max_key)
	);

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_keyed_table_unit. A directed opening covers
// the empty table, the extreme keys and handles, repeated keys, a full table
// and the unused op code. Random traffic follows, with keys drawn mostly from
// a small pool so that finds hit. A table tracker predicts every response
// beat and compares it field by field with the beat that arrives.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = skt_pkg::DEPTH_DEF;
	localparam int KEY_BITS     = skt_pkg::KEY_BITS_DEF;
	localparam int HANDLE_BITS  = skt_pkg::HANDLE_BITS_DEF;
	localparam int CNT_BITS     = $clog2(DEPTH + 1);
	localparam int RANDOM_ITEMS = 750;
	localparam int QUIET_ITEMS  = 80;

	// op code the block leaves unused
	localparam skt_pkg::op_t OP_UNUSED = 2'd3;

	typedef logic [KEY_BITS-1:0]    key_t;
	typedef logic [HANDLE_BITS-1:0] handle_t;

	typedef struct packed {
		skt_pkg::status_t    status;
		handle_t             found_handle;
		logic [CNT_BITS-1:0] count;
		key_t                max_key;
	} table_rsp_t;

	class table_tracker;
		key_t       keys[DEPTH];
		handle_t    handles[DEPTH];
		int         held;
		table_rsp_t expected_rsps[$];
		int         mismatch_count;

		function new();
			held = 0;
			mismatch_count = 0;
		endfunction

		function table_rsp_t apply_op(skt_pkg::op_t op, key_t key, handle_t handle);
			table_rsp_t r;
			int         pos;
			int         i;
			r = '0;
			r.status = skt_pkg::ST_OK;
			case (op)
				skt_pkg::OP_INSERT: begin
					if (held >= DEPTH) begin
						r.status = skt_pkg::ST_FULL;
					end else begin
						// new entry goes after every key less than or equal
						pos = 0;
						while (pos < held && keys[pos] <= key)
							pos++;
						for (i = held; i > pos; i--) begin
							keys[i]    = keys[i-1];
							handles[i] = handles[i-1];
						end
						keys[pos]    = key;
						handles[pos] = handle;
						held++;
					end
				end
				skt_pkg::OP_FIND: begin
					r.status = skt_pkg::ST_NOT_FOUND;
					for (i = 0; i < held; i++) begin
						if (keys[i] == key) begin
							r.status       = skt_pkg::ST_OK;
							r.found_handle = handles[i];
							break;
						end
					end
				end
				skt_pkg::OP_CLEAR: begin
					held = 0;
				end
				default: begin
				end
			endcase
			r.count   = held[CNT_BITS-1:0];
			r.max_key = (held == 0) ? '0 : keys[held-1];
			return r;
		endfunction

		function void note_request(skt_pkg::op_t op, key_t key, handle_t handle);
			expected_rsps.push_back(apply_op(op, key, handle));
		endfunction

		function void check_response(table_rsp_t got);
			table_rsp_t want;
			if (expected_rsps.size() == 0) begin
				$error("response beat with no request outstanding");
				mismatch_count++;
				return;
			end
			want = expected_rsps.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				mismatch_count++;
			end
			if (got.found_handle !== want.found_handle) begin
				$error("found_handle: expected %h, actual %h",
					want.found_handle, got.found_handle);
				mismatch_count++;
			end
			if (got.count !== want.count) begin
				$error("count: expected %0d, actual %0d", want.count, got.count);
				mismatch_count++;
			end
			if (got.max_key !== want.max_key) begin
				$error("max_key: expected %h, actual %h", want.max_key, got.max_key);
				mismatch_count++;
			end
		endfunction

		function int outstanding();
			return expected_rsps.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;

	table_tracker tracker;

	skt_req_if #(.KEY_BITS(KEY_BITS), .HANDLE_BITS(HANDLE_BITS)) req();
	skt_rsp_if #(.KEY_BITS(KEY_BITS), .HANDLE_BITS(HANDLE_BITS),
		.CNT_BITS(CNT_BITS)) rsp();

	sorted_keyed_table_unit #(
		.DEPTH(DEPTH),
		.KEY_BITS(KEY_BITS),
		.HANDLE_BITS(HANDLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// a few repeated values so that finds and equal-key inserts happen often
	function automatic key_t pick_key();
		key_t pool[8];
		pool = '{16'h0000, 16'h0001, 16'h0002, 16'h0007,
			16'h00ff, 16'h1234, 16'h8000, 16'hffff};
		if ($urandom_range(0, 9) < 6)
			return pool[$urandom_range(0, 7)];
		return key_t'($urandom);
	endfunction

	function automatic skt_pkg::op_t pick_op();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 48)
			return skt_pkg::OP_INSERT;
		if (r < 93)
			return skt_pkg::OP_FIND;
		if (r < 96)
			return skt_pkg::OP_CLEAR;
		return OP_UNUSED;
	endfunction

	// holds the beat until it is taken; valid is left high for the caller
	task automatic send_request(skt_pkg::op_t op, key_t key, handle_t handle);
		req.valid  <= 1'b1;
		req.op     <= op;
		req.key    <= key;
		req.handle <= handle;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		tracker.note_request(op, key, handle);
	endtask

	task automatic maybe_pause_sender();
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// response side: random stall bursts, none once the run goes quiet
	initial begin
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
			tracker.check_response('{rsp.status, rsp.found_handle, rsp.count,
				rsp.max_key});
	end

	initial begin
		#2ms;
		$display("sorted_keyed_table_unit verification failed");
		$finish;
	end

	initial begin
		int i;
		tracker = new();
		quiet = 1'b0;
		arst_n     <= 1'b0;
		req.valid  <= 1'b0;
		req.op     <= skt_pkg::OP_INSERT;
		req.key    <= '0;
		req.handle <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, extreme keys and handles, repeated keys
		send_request(skt_pkg::OP_FIND, 16'h1234, 16'hffff);
		send_request(OP_UNUSED, 16'hffff, 16'hffff);
		send_request(skt_pkg::OP_INSERT, 16'hffff, 16'hffff);
		send_request(skt_pkg::OP_INSERT, 16'h0000, 16'h0000);
		send_request(skt_pkg::OP_INSERT, 16'h0005, 16'ha001);
		send_request(skt_pkg::OP_INSERT, 16'h0005, 16'ha002);
		send_request(skt_pkg::OP_INSERT, 16'h0005, 16'ha003);
		send_request(skt_pkg::OP_FIND, 16'h0005, 16'h5555);
		send_request(skt_pkg::OP_FIND, 16'hffff, 16'h0000);
		send_request(skt_pkg::OP_FIND, 16'h0000, 16'hffff);
		send_request(skt_pkg::OP_FIND, 16'h0006, 16'h0000);
		send_request(OP_UNUSED, 16'h0005, 16'h1234);
		// fill up, then one refused insert
		for (i = 0; i < DEPTH - 5; i++)
			send_request(skt_pkg::OP_INSERT, key_t'($urandom), handle_t'($urandom));
		send_request(skt_pkg::OP_INSERT, 16'h0003, 16'hbeef);
		send_request(skt_pkg::OP_CLEAR, 16'hffff, 16'hffff);
		send_request(skt_pkg::OP_FIND, 16'h0005, 16'h0000);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i >= RANDOM_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			maybe_pause_sender();
			send_request(pick_op(), pick_key(), handle_t'($urandom));
		end
		req.valid <= 1'b0;

		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.mismatch_count == 0)
			$display("sorted_keyed_table_unit verification clean");
		else
			$display("sorted_keyed_table_unit verification failed");
		$finish;
	end

endmodule
